@@ src/lpam_pkg.sv @@
package lpam_pkg;

  // Table geometry; TABLE_DEPTH is a power of two
  localparam int TABLE_DEPTH = 4096;
  localparam int HASH_SHIFT  = 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 13;
  localparam int KEY_W       = 64;
  localparam int LOC_W       = 64;

  typedef enum logic [2:0] {
    STAT_HIT      = 3'd0,
    STAT_MISS     = 3'd1,
    STAT_INSERTED = 3'd2,
    STAT_UPDATED  = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_ZERO_LOC = 3'd5
  } status_t;

  typedef enum logic {
    KIND_LOOKUP = 1'b0,
    KIND_SET    = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } state_t;

endpackage

@@ src/linear_probe_address_map_unit.sv @@
// Guest-to-host address map: a 4096-slot open-addressed table, probed linearly
// from home slot guest_address[15:4]. After reset the block sweeps the table to
// zero, one slot per cycle, and holds busy high while it does so. An item
// is taken when start is high and busy is low; it then reads one slot per cycle
// through the single table read port until it finds the key, an empty slot, or
// has visited every slot. An item that visits k slots (1 to 4096) keeps busy
// high while it probes, so a new item is taken only once the last is done. The
// result is shown for exactly one cycle with out_valid and cannot be stalled;
// the next item may be started in that same cycle.
module linear_probe_address_map_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_kind,
  input  logic [63:0]                 in_guest_address,
  input  logic [63:0]                 in_host_location,
  output logic                        out_valid,
  output logic [2:0]                  out_status,
  output logic [63:0]                 out_found_location,
  output logic [lpam_pkg::COUNT_W-1:0] out_entries_used
);
  import lpam_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  // Sequencer and item registers
  state_t               state_r, state_nxt;
  logic                 kind_r, kind_nxt;
  logic [KEY_W-1:0]     addr_r, addr_nxt;
  logic [LOC_W-1:0]     loc_r, loc_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [IDX_W-1:0]     n_r, n_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [LOC_W-1:0]     out_found_r, out_found_nxt;
  logic [COUNT_W-1:0]   out_used_r, out_used_nxt;

  // Table memory: key in the upper half, location in the lower half
  logic [KEY_W+LOC_W-1:0] mem [TABLE_DEPTH];
  logic [KEY_W+LOC_W-1:0] rd_data_r;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_waddr, mem_raddr;
  logic [KEY_W+LOC_W-1:0] mem_wdata;

  logic [KEY_W-1:0]       rd_key;
  logic [LOC_W-1:0]       rd_loc;
  logic                   slot_empty, slot_match, probe_last;
  logic [IDX_W-1:0]       idx_inc;
  logic [IDX_W-1:0]       home_slot;

  assign rd_key     = rd_data_r[KEY_W+LOC_W-1:LOC_W];
  assign rd_loc     = rd_data_r[LOC_W-1:0];
  assign slot_empty = (rd_loc == '0);
  assign slot_match = slot_empty || (rd_key == addr_r);
  assign probe_last = (n_r == LAST_IDX);
  assign idx_inc    = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;
  assign home_slot  = in_guest_address[HASH_SHIFT +: IDX_W];

  // Write and read the table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    addr_r       <= addr_nxt;
    loc_r        <= loc_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_used_r   <= out_used_nxt;
  end

  // Sequence clearing, probing and result
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    addr_nxt       = addr_r;
    loc_nxt        = loc_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    count_nxt      = count_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_used_nxt   = out_used_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = idx_r;

    case (state_r)
      ST_CLEAR: begin
        // Zero one slot per cycle
        mem_we  = 1'b1;
        idx_nxt = idx_inc;
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        // Latch the beat and read its home slot
        if (start) begin
          kind_nxt  = in_kind;
          addr_nxt  = in_guest_address;
          loc_nxt   = in_host_location;
          idx_nxt   = home_slot;
          n_nxt     = '0;
          mem_re    = 1'b1;
          mem_raddr = home_slot;
          state_nxt = ST_PROBE;
        end
      end

      ST_PROBE: begin
        if (!slot_match && !probe_last) begin
          // Advance to the next slot, wrapping at the end
          idx_nxt   = idx_inc;
          n_nxt     = n_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = idx_inc;
        end else begin
          // Decide the result and, for an insert or an update, write the slot
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = '0;
          if (kind_r == KIND_LOOKUP) begin
            if (slot_match && !slot_empty) begin
              out_status_nxt = STAT_HIT;
              out_found_nxt  = rd_loc;
            end else begin
              out_status_nxt = STAT_MISS;
            end
          end else if (loc_r == '0) begin
            out_status_nxt = STAT_ZERO_LOC;
          end else if (!slot_match) begin
            out_status_nxt = STAT_FULL;
          end else if (!slot_empty) begin
            mem_we         = 1'b1;
            mem_wdata      = {rd_key, loc_r};
            out_status_nxt = STAT_UPDATED;
          end else begin
            mem_we         = 1'b1;
            mem_wdata      = {addr_r, loc_r};
            count_nxt      = count_r + 1'b1;
            out_status_nxt = STAT_INSERTED;
          end
          out_used_nxt = count_nxt;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_location = out_found_r;
  assign out_entries_used   = out_used_r;

  // A result only follows a probe cycle
  a_result_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r) == ST_PROBE)
    else $error("result strobe without a preceding probe");

  // Accepted beat starts a probe
  a_start_probes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == ST_PROBE)
    else $error("accepted beat did not start a probe");

  // Count never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // An insert bumps the count by one
  a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_INSERTED) |->
      count_r == $past(count_r) + 1'b1)
    else $error("insert without count increment");

endmodule

@@ tb/tb.sv @@
module tb;
  import lpam_pkg::*;

  // One result beat as the block should present it
  typedef struct {
    status_t              status;
    logic [LOC_W-1:0]     found;
    logic [COUNT_W-1:0]   used;
  } map_reply_t;

  // Shadow table of the address map and the replies still owed by the block
  class map_scoreboard;
    bit [KEY_W-1:0] key_tbl [TABLE_DEPTH];
    bit [LOC_W-1:0] loc_tbl [TABLE_DEPTH];
    int             used_slots;
    logic [KEY_W-1:0] stored_keys [$];
    map_reply_t     due_replies [$];
    int             errors;
    int             accepted;
    int             checked;

    // Print the first mismatches, count them all
    task report(input string msg);
      if (errors < 100) $display("tb: mismatch: %s", msg);
      errors++;
    endtask

    // Walk from the home slot until the key or an empty slot; one pass at most
    function bit find_slot(input logic [KEY_W-1:0] addr, output int slot);
      int idx;
      idx = int'((addr >> HASH_SHIFT) & 64'(TABLE_DEPTH - 1));
      for (int n = 0; n < TABLE_DEPTH; n++) begin
        if (loc_tbl[idx] == 0 || key_tbl[idx] == addr) begin
          slot = idx;
          return 1'b1;
        end
        idx = (idx + 1) % TABLE_DEPTH;
      end
      slot = 0;
      return 1'b0;
    endfunction

    // Apply one lookup or set to the shadow table and form its reply
    function map_reply_t resolve_access(input kind_t kind, input logic [KEY_W-1:0] addr,
                                        input logic [LOC_W-1:0] loc);
      map_reply_t r;
      int         slot;
      bit         ok;
      ok = find_slot(addr, slot);
      r.found = '0;
      if (kind == KIND_LOOKUP) begin
        if (ok && loc_tbl[slot] != 0) begin
          r.status = STAT_HIT;
          r.found  = loc_tbl[slot];
        end else begin
          r.status = STAT_MISS;
        end
      end else if (loc == 0) begin
        r.status = STAT_ZERO_LOC;
      end else if (!ok) begin
        r.status = STAT_FULL;
      end else if (loc_tbl[slot] != 0) begin
        loc_tbl[slot] = loc;
        r.status = STAT_UPDATED;
      end else begin
        key_tbl[slot] = addr;
        loc_tbl[slot] = loc;
        used_slots++;
        stored_keys.push_back(addr);
        r.status = STAT_INSERTED;
      end
      r.used = used_slots[COUNT_W-1:0];
      return r;
    endfunction

    function void note_item(input kind_t kind, input logic [KEY_W-1:0] addr,
                            input logic [LOC_W-1:0] loc);
      due_replies.push_back(resolve_access(kind, addr, loc));
      accepted++;
    endfunction

    // Compare a result beat against the oldest owed reply
    task check_result(input logic [2:0] status, input logic [LOC_W-1:0] found,
                      input logic [COUNT_W-1:0] used);
      map_reply_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("result with nothing outstanding: status %0d", status));
        return;
      end
      want = due_replies.pop_front();
      checked++;
      if (status !== want.status)
        report($sformatf("reply %0d status %0d, want %s", checked, status, want.status.name()));
      if (found !== want.found)
        report($sformatf("reply %0d location %h, want %h", checked, found, want.found));
      if (used !== want.used)
        report($sformatf("reply %0d entries %0d, want %0d", checked, used, want.used));
    endtask

    function int pending();
      return due_replies.size();
    endfunction
  endclass

  localparam int          RAND_PER_PHASE = 172;
  localparam logic [63:0] FILL_TAG       = 64'hC0DE_5A5A_0000_0000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic                 in_kind;
  logic [63:0]          in_guest_address;
  logic [63:0]          in_host_location;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [63:0]          out_found_location;
  logic [COUNT_W-1:0]   out_entries_used;

  map_scoreboard        sb;
  int                   idle_pct;

  linear_probe_address_map_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_guest_address   (in_guest_address),
    .in_host_location   (in_host_location),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_location (out_found_location),
    .out_entries_used   (out_entries_used)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Check every result beat at the edge that ends it
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_found_location, out_entries_used);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Keys piled onto a few neighboring home slots around the wrap point, or anywhere
  function automatic logic [63:0] fresh_address();
    logic [63:0] a;
    int          h;
    a = rand64();
    if ($urandom_range(1) == 0) begin
      h = $urandom_range(13);
      a[15:4] = (h < 6) ? 12'(4090 + h) : 12'(h - 6);
    end
    return a;
  endfunction

  function automatic logic [63:0] known_key();
    return sb.stored_keys[$urandom_range(sb.stored_keys.size() - 1)];
  endfunction

  function automatic logic [63:0] pick_location();
    logic [63:0] l;
    case ($urandom_range(9))
      0: l = '1;
      1: l = 64'd1;
      default: l = rand64();
    endcase
    if (l == 0) l = 64'd1;
    return l;
  endfunction

  // Hold start low for one cycle with junk on the fields
  task automatic idle_cycle();
    @(negedge clk);
    start            = 1'b0;
    in_kind          = 1'($urandom_range(1));
    in_guest_address = rand64();
    in_host_location = rand64();
  endtask

  // Present one beat and hold it until the block takes it
  task automatic send_item(input kind_t kind, input logic [63:0] addr, input logic [63:0] loc);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    @(negedge clk);
    start            = 1'b1;
    in_kind          = kind;
    in_guest_address = addr;
    in_host_location = loc;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_item(kind, addr, loc);
  endtask

  // Drop start and wait until every owed reply is back
  task automatic drain_replies();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45 || sb.stored_keys.size() == 0)
      send_item(KIND_SET, fresh_address(), pick_location());
    else if (pick < 65)
      send_item(KIND_SET, known_key(), pick_location());
    else if (pick < 85)
      send_item(KIND_LOOKUP, known_key(), rand64());
    else if (pick < 95)
      send_item(KIND_LOOKUP, fresh_address(), rand64());
    else if (pick < 97)
      send_item(KIND_SET, known_key(), 64'd0);
    else
      send_item(KIND_SET, fresh_address(), 64'd0);
  endtask

  // Stop a hung run
  initial begin
    #250_000_000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    int guard;
    sb               = new();
    idle_pct         = 0;
    rst_n            = 1'b0;
    start            = 1'b0;
    in_kind          = 1'b0;
    in_guest_address = '0;
    in_host_location = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, key zero, zero location, wrap at the table end
    send_item(KIND_LOOKUP, 64'd0, '1);
    send_item(KIND_SET, 64'd0, '1);
    send_item(KIND_LOOKUP, 64'd0, 64'd0);
    send_item(KIND_SET, 64'd0, 64'd0);
    send_item(KIND_SET, 64'd0, 64'd1);
    send_item(KIND_SET, '1, 64'h8000_0000_0000_0000);
    send_item(KIND_SET, 64'h0000_0000_0000_FFF0, 64'h0123_4567_89AB_CDEF);
    send_item(KIND_LOOKUP, 64'h0000_0000_0000_FFF0, '0);
    send_item(KIND_LOOKUP, 64'h0000_0001_0000_FFF0, '1);
    send_item(KIND_SET, 64'h0000_0001_0000_0010, 64'hFEDC_BA98_7654_3210);
    send_item(KIND_SET, 64'h0000_0000_0000_FFF0, 64'h5555_AAAA_5555_AAAA);
    send_item(KIND_LOOKUP, '1, '0);
    send_item(KIND_SET, 64'h0000_0000_0000_0005, 64'h0000_0000_FFFF_FFFF);
    send_item(KIND_LOOKUP, 64'h0000_0000_0000_0005, '0);
    send_item(KIND_LOOKUP, 64'h0000_0000_0000_000F, '0);
    send_item(KIND_LOOKUP, 64'h0000_0001_0000_0010, '1);
    drain_replies();

    // Random mix over three idling regimes, with an occasional full pause
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 16 : (phase == 1) ? 59 : 0;
      repeat (RAND_PER_PHASE) begin
        random_item();
        if ($urandom_range(59) == 0) drain_replies();
      end
    end
    drain_replies();

    // Tail: fresh keys, zero location on a tagged key, updates and lookups
    idle_pct = 10;
    send_item(KIND_SET, fresh_address(), pick_location());
    send_item(KIND_SET, rand64(), '1);
    send_item(KIND_LOOKUP, rand64(), rand64());
    send_item(KIND_SET, 64'd0, 64'h0F0F_0F0F_0F0F_0F0F);
    send_item(KIND_LOOKUP, 64'd0, '0);
    send_item(KIND_SET, FILL_TAG | (64'd77 << HASH_SHIFT), 64'd0);
    send_item(KIND_LOOKUP, FILL_TAG | (64'd77 << HASH_SHIFT), '1);
    send_item(KIND_SET, FILL_TAG | (64'd4095 << HASH_SHIFT), '1);
    repeat (10) begin
      if ($urandom_range(4) == 0) send_item(KIND_LOOKUP, fresh_address(), rand64());
      else if ($urandom_range(1) == 0) send_item(KIND_SET, known_key(), pick_location());
      else send_item(KIND_LOOKUP, known_key(), rand64());
    end

    // Wait out the last replies, then a few quiet cycles for strays
    @(negedge clk);
    start = 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d replies never arrived", sb.pending()));
    repeat (20) @(posedge clk);

    $display("tb: %0d lookups and sets: collisions, wrapped probes, key zero, zero locations",
             sb.accepted);
    $display("tb: table held %0d of %0d slots at the end; %0d replies checked",
             sb.used_slots, TABLE_DEPTH, sb.checked);
    if (sb.errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
